// ===== hw/rtl/longest_increasing_subsequence_top_defines.svh =====
// assertion macros for the longest increasing subsequence block
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef LONGEST_INCREASING_SUBSEQUENCE_TOP_DEFINES_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define LIS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LIS_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define LIS_ASSERT(label, clk, rst, prop, msg)
`define LIS_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ===== hw/rtl/lis_pkg.sv =====
// shared types and field widths for the longest increasing subsequence block
// no dependencies
package lis_pkg;

   localparam int VALUE_W   = 32;
   localparam int OUT_LEN_W = 11;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP_LAST,
      ST_CMP_MID,
      ST_DONE
   } lis_state_type;

endpackage

// ===== hw/rtl/lis_req_if.sv =====
// request channel: value, start and last flags with valid/ready
// depends on lis_pkg
interface lis_req_if;
   import lis_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic               start_req;
   logic               last;

   modport source (output valid, output value, output start_req, output last, input ready);
   modport sink   (input valid, input value, input start_req, input last, output ready);
endinterface

// ===== hw/rtl/lis_rsp_if.sv =====
// response channel: length, final flag and overflow flag with valid/ready
// depends on lis_pkg
interface lis_rsp_if;
   import lis_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OUT_LEN_W-1:0] lis_length;
   logic                 final_res;
   logic                 overflow;

   modport source (output valid, output lis_length, output final_res, output overflow,
                   input ready);
   modport sink   (input valid, input lis_length, input final_res, input overflow,
                   output ready);
endinterface

// ===== hw/rtl/longest_increasing_subsequence_top.sv =====
// longest increasing subsequence, patience-sorting tails kept in lis_ram
// depends on lis_pkg, lis_req_if, lis_rsp_if, lis_ram and the defines header
// an empty list takes the key directly; otherwise the last tail is read and compared, and a greater
// key is appended, else the tail to replace is found by a search, one compare per cycle in a shared comparator
// ready only while idle, so each request finishes before the next is taken; a stalled response holds it
// synchronous active-high reset clears length, overflow, state and response valid
`include "longest_increasing_subsequence_top_defines.svh"

module longest_increasing_subsequence_top #(
   parameter int CAPACITY   = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   lis_req_if.sink   req_ch,
   lis_rsp_if.source rsp_ch
);
   import lis_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAPACITY);

   lis_state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] key_ff, key_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  ovf_ff, ovf_in;
   logic                  last_ff, last_in;
   logic [IDX_W-1:0]      lo_ff, lo_in;
   logic [IDX_W-1:0]      hi_ff, hi_in;
   logic [IDX_W-1:0]      mid_ff, mid_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_LEN_W-1:0]  rsp_len_ff;
   logic                  rsp_final_ff;
   logic                  rsp_ovf_ff;
   logic                  rsp_load;

   logic [VALUE_BITS-1:0] val_ext;
   logic [VALUE_BITS-1:0] key_new;
   logic [LEN_W-1:0]      len_base;
   logic [LEN_W-1:0]      len_m1;
   logic [IDX_W-1:0]      last_idx;
   logic [OUT_LEN_W-1:0]  out_len;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [VALUE_BITS-1:0] rd_data;

   logic                  key_gt;
   logic [IDX_W-1:0]      lo_n;
   logic [IDX_W-1:0]      hi_n;
   logic [IDX_W:0]        mid_sum;
   logic [IDX_W-1:0]      mid_n;
   logic                  search_more;

   // sign-flipped key keeps signed order under unsigned compare
   generate
      if (VALUE_BITS <= VALUE_W) begin : g_val_narrow
         assign val_ext = req_ch.value[VALUE_BITS-1:0];
      end else begin : g_val_wide
         assign val_ext = {{(VALUE_BITS - VALUE_W){1'b0}}, req_ch.value};
      end
      if (LEN_W >= OUT_LEN_W) begin : g_len_trunc
         assign out_len = len_ff[OUT_LEN_W-1:0];
      end else begin : g_len_ext
         assign out_len = {{(OUT_LEN_W - LEN_W){1'b0}}, len_ff};
      end
   endgenerate

   assign key_new  = {~val_ext[VALUE_BITS-1], val_ext[VALUE_BITS-2:0]};
   assign len_base = req_ch.start_req ? '0 : len_ff;
   assign len_m1   = len_base - LEN_W'(1);
   assign last_idx = len_m1[IDX_W-1:0];

   // shared compare and search step
   assign key_gt      = key_ff > rd_data;
   assign lo_n        = key_gt ? (mid_ff + IDX_W'(1)) : lo_ff;
   assign hi_n        = key_gt ? hi_ff : mid_ff;
   assign mid_sum     = {1'b0, lo_n} + {1'b0, hi_n};
   assign mid_n       = mid_sum[IDX_W:1];
   assign search_more = lo_n < hi_n;

   lis_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (CAPACITY)
   ) u_tails (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = (len_base == '0) ? ST_DONE : ST_CMP_LAST;
            end
         end
         ST_CMP_LAST: begin
            if (key_gt || hi_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_CMP_MID;
            end
         end
         ST_CMP_MID: begin
            if (!search_more) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = lo_n;
      wr_data  = key_ff;
      rd_en    = 1'b0;
      rd_addr  = mid_n;
      key_in   = key_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      last_in  = last_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               key_in  = key_new;
               last_in = req_ch.last;
               ovf_in  = req_ch.start_req ? 1'b0 : ovf_ff;
               len_in  = len_base;
               lo_in   = '0;
               hi_in   = last_idx;
               if (len_base == '0) begin
                  wr_en   = 1'b1;
                  wr_addr = '0;
                  wr_data = key_new;
                  len_in  = LEN_W'(1);
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = last_idx;
               end
            end
         end
         ST_CMP_LAST: begin
            if (key_gt) begin
               if (len_ff < LEN_CAP) begin
                  wr_en   = 1'b1;
                  wr_addr = len_ff[IDX_W-1:0];
                  len_in  = len_ff + LEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end else if (hi_ff == '0) begin
               wr_en   = 1'b1;
               wr_addr = '0;
            end else begin
               mid_in  = hi_ff >> 1;
               rd_en   = 1'b1;
               rd_addr = hi_ff >> 1;
            end
         end
         ST_CMP_MID: begin
            lo_in = lo_n;
            hi_in = hi_n;
            if (search_more) begin
               mid_in  = mid_n;
               rd_en   = 1'b1;
               rd_addr = mid_n;
            end else begin
               wr_en   = 1'b1;
               wr_addr = lo_n;
            end
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      last_ff <= last_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      if (rsp_load) begin
         rsp_len_ff   <= out_len;
         rsp_final_ff <= last_ff;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.lis_length = rsp_len_ff;
   assign rsp_ch.final_res  = rsp_final_ff;
   assign rsp_ch.overflow   = rsp_ovf_ff;

   `LIS_ASSERT_NEVER(a_len_cap, clock, reset, len_ff > LEN_CAP, "length above capacity")
   `LIS_ASSERT(a_ovf_full, clock, reset, ovf_ff |-> (len_ff == LEN_CAP), "overflow below capacity")
   `LIS_ASSERT(a_mid_range, clock, reset, (state_ff == ST_CMP_MID) |-> (mid_ff >= lo_ff && mid_ff < hi_ff), "search midpoint out of range")
   `LIS_ASSERT(a_rsp_src, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE), "response without finished request")

endmodule

// ===== hw/rtl/lis_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module lis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
